>>> design/mpi_reduction_alu_macros.svh
// assertion macros for the reduction unit
// each check samples on clk and stays quiet while rst is high
`ifndef MPI_REDUCTION_ALU_MACROS_SVH
`define MPI_REDUCTION_ALU_MACROS_SVH
`ifndef ASSERT_OFF
`define MPIRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MPIRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPIRA_ASSERT_SAME(lbl, ante, cons, msg)
`define MPIRA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/mpira_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpira_pkg;

  // reduction operation codes
  typedef enum logic [3:0] {
    OP_MAX     = 4'd0,
    OP_MIN     = 4'd1,
    OP_SUM     = 4'd2,
    OP_PROD    = 4'd3,
    OP_LAND    = 4'd4,
    OP_LOR     = 4'd5,
    OP_LXOR    = 4'd6,
    OP_BAND    = 4'd7,
    OP_BOR     = 4'd8,
    OP_BXOR    = 4'd9,
    OP_MAXLOC  = 4'd10,
    OP_MINLOC  = 4'd11,
    OP_REPLACE = 4'd12,
    OP_NOOP    = 4'd13
  } op_t;

  // element type classes
  typedef enum logic [1:0] {
    CLS_INT  = 2'd0,
    CLS_BOOL = 2'd1,
    CLS_BYTE = 2'd2,
    CLS_PAIR = 2'd3
  } class_t;

  // value width codes
  localparam logic [1:0] VW_8  = 2'd0;
  localparam logic [1:0] VW_16 = 2'd1;
  localparam logic [1:0] VW_32 = 2'd2;
  localparam logic [1:0] VW_64 = 2'd3;

  // register indexes on the config port
  localparam logic [2:0] REG_OPERATION = 3'd0;
  localparam logic [2:0] REG_WIDTH     = 3'd1;
  localparam logic [2:0] REG_SIGNED    = 3'd2;
  localparam logic [2:0] REG_CLASS     = 3'd3;
  localparam logic [2:0] REG_IDX_WIDE  = 3'd4;

  localparam int AddrWidth = 5;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] vcode;
    logic       sgn;
    class_t     cls;
    logic       iwide;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{op: OP_MAX, vcode: VW_32, sgn: 1'b1, cls: CLS_INT, iwide: 1'b0};

  // bool and byte elements are always 8 bits wide
  function automatic logic [1:0] eff_vcode(cfg_t c);
    return (c.cls == CLS_BOOL || c.cls == CLS_BYTE) ? VW_8 : c.vcode;
  endfunction

  function automatic logic [63:0] value_mask(cfg_t c);
    logic [63:0] m;
    case (eff_vcode(c))
      VW_8:    m = 64'h0000_0000_0000_00FF;
      VW_16:   m = 64'h0000_0000_0000_FFFF;
      VW_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] value_top_bit(cfg_t c);
    logic [63:0] t;
    case (eff_vcode(c))
      VW_8:    t = 64'h0000_0000_0000_0080;
      VW_16:   t = 64'h0000_0000_0000_8000;
      VW_32:   t = 64'h0000_0000_8000_0000;
      default: t = 64'h8000_0000_0000_0000;
    endcase
    return t;
  endfunction

  function automatic logic [63:0] index_mask(cfg_t c);
    return c.iwide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  endfunction

  function automatic logic [63:0] index_top_bit(cfg_t c);
    return c.iwide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
  endfunction

endpackage

`default_nettype wire

>>> design/mpi_reduction_alu.sv
// mpi_reduction_alu: element-wise reduction operators over a valid/ready stream
// path: an element passes the input, product and output registers before out_valid rises
// throughput: one element per cycle while out_ready holds; the 64-bit product is split into 32x32 partial
//   products registered in stage 2 and folded into the output register, which sets the depth
// reset: rst (synchronous) empties all stages and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "mpi_reduction_alu_macros.svh"

module mpi_reduction_alu (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // config port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mpira_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // element stream
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [63:0]                     in_value,
  input  wire logic [63:0]                     acc_value,
  input  wire logic [63:0]                     in_index,
  input  wire logic [63:0]                     acc_index,
  input  wire logic                            last_element,
  // result stream
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [63:0]                     out_value,
  output logic      [63:0]                     out_index,
  output logic                                 type_error,
  output logic                                 last_result
);
  import mpira_pkg::*;

  cfg_t        cfg;
  logic [2:0]  reg_sel;
  logic        cfg_write;

  logic        s1_valid;
  logic        s1_ready;
  logic [63:0] s1_in_value;
  logic [63:0] s1_acc_value;
  logic [63:0] s1_in_index;
  logic [63:0] s1_acc_index;
  logic        s1_last;

  logic [63:0] a_masked;
  logic [63:0] b_masked;
  logic [63:0] ai_masked;
  logic [63:0] bi_masked;
  logic [63:0] comb_value;
  logic [63:0] comb_index;
  logic        comb_err;
  logic        comb_use_prod;

  logic        s2_valid;
  logic        s2_ready;
  logic        s2_load;
  logic [63:0] s2_value;
  logic [63:0] s2_index;
  logic        s2_err;
  logic        s2_use_prod;
  logic        s2_last;
  logic [63:0] vprod;
  logic [63:0] iprod;

  logic        s3_ready;
  logic [63:0] out_value_next;
  logic [63:0] out_index_next;

  // config register file
  assign pready    = 1'b1;
  assign reg_sel   = paddr[AddrWidth-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_OPERATION: cfg.op    <= pwdata[3:0];
        REG_WIDTH:     cfg.vcode <= pwdata[1:0];
        REG_SIGNED:    cfg.sgn   <= pwdata[0];
        REG_CLASS:     cfg.cls   <= class_t'(pwdata[1:0]);
        REG_IDX_WIDE:  cfg.iwide <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OPERATION: prdata = {28'h0, cfg.op};
      REG_WIDTH:     prdata = {30'h0, cfg.vcode};
      REG_SIGNED:    prdata = {31'h0, cfg.sgn};
      REG_CLASS:     prdata = {30'h0, cfg.cls};
      REG_IDX_WIDE:  prdata = {31'h0, cfg.iwide};
      default:       prdata = 32'h0;
    endcase
  end

  // stage handshake, each stage moves when the next one has room
  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign s2_load  = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // input register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_in_value  <= in_value;
      s1_acc_value <= acc_value;
      s1_in_index  <= in_index;
      s1_acc_index <= acc_index;
      s1_last      <= last_element;
    end
  end

  // everything but the product settles in this stage
  mpira_combine u_combine (
    .cfg       (cfg),
    .in_value  (s1_in_value),
    .acc_value (s1_acc_value),
    .in_index  (s1_in_index),
    .acc_index (s1_acc_index),
    .a_masked  (a_masked),
    .b_masked  (b_masked),
    .ai_masked (ai_masked),
    .bi_masked (bi_masked),
    .value     (comb_value),
    .index     (comb_index),
    .err       (comb_err),
    .use_prod  (comb_use_prod)
  );

  // value and index products, partial products registered with stage 2
  mpira_mul_lo u_mul_value (
    .clk  (clk),
    .en   (s2_load),
    .a    (a_masked),
    .b    (b_masked),
    .prod (vprod)
  );

  mpira_mul_lo u_mul_index (
    .clk  (clk),
    .en   (s2_load),
    .a    (ai_masked),
    .b    (bi_masked),
    .prod (iprod)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_value    <= comb_value;
      s2_index    <= comb_index;
      s2_err      <= comb_err;
      s2_use_prod <= comb_use_prod;
      s2_last     <= s1_last;
    end
  end

  // pick the finished product where the operation asks for it
  always_comb begin
    out_value_next = s2_value;
    out_index_next = s2_index;
    if (s2_use_prod) begin
      out_value_next = vprod & value_mask(cfg);
      if (cfg.cls == CLS_PAIR) begin
        out_index_next = iprod & index_mask(cfg);
      end
    end
  end

  // output register, holds a result until its transfer
  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      out_value   <= out_value_next;
      out_index   <= out_index_next;
      type_error  <= s2_err;
      last_result <= s2_last;
    end
  end

  // checks on the stage control
  `MPIRA_ASSERT_SAME(a_ready_chain, out_ready, in_ready, "input stalled with output free")
  `MPIRA_ASSERT_NEXT(a_s2_hold, s2_valid && !s3_ready, s2_valid, "stage 2 dropped an element")
  `MPIRA_ASSERT_SAME(a_out_source, $rose(out_valid), $past(s2_valid), "result without element")

endmodule

`default_nettype wire

>>> design/mpira_mul_lo.sv
`timescale 1ns / 1ps
`default_nettype none

module mpira_mul_lo (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] prod
);

  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;

  // 32x32 partial products, only the low 64 bits of the full product are kept
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= 64'(a[31:0]) * 64'(b[31:0]);
      p_lh <= 32'(a[31:0] * b[63:32]);
      p_hl <= 32'(a[63:32] * b[31:0]);
    end
  end

  // fold the cross terms into the upper half
  assign prod = p_ll + {p_lh + p_hl, 32'h0};

endmodule

`default_nettype wire

>>> design/mpira_combine.sv
`timescale 1ns / 1ps
`default_nettype none

module mpira_combine (
  input  wire mpira_pkg::cfg_t  cfg,
  input  wire logic [63:0]      in_value,
  input  wire logic [63:0]      acc_value,
  input  wire logic [63:0]      in_index,
  input  wire logic [63:0]      acc_index,
  output logic      [63:0]      a_masked,
  output logic      [63:0]      b_masked,
  output logic      [63:0]      ai_masked,
  output logic      [63:0]      bi_masked,
  output logic      [63:0]      value,
  output logic      [63:0]      index,
  output logic                  err,
  output logic                  use_prod
);
  import mpira_pkg::*;

  logic [63:0] vm;
  logic [63:0] im;
  logic [63:0] vflip;
  logic [63:0] iflip;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] rv;
  logic [63:0] ri;
  logic        ta;
  logic        tb;
  logic        pair;
  logic        narrow;
  logic        a_lt_b;
  logic        b_lt_a;
  logic        ai_lt_bi;
  logic        take_in;

  // masks and sign flips for the configured widths
  always_comb begin
    vm     = value_mask(cfg);
    im     = index_mask(cfg);
    vflip  = cfg.sgn ? value_top_bit(cfg) : 64'h0;
    iflip  = index_top_bit(cfg);
    pair   = (cfg.cls == CLS_PAIR);
    narrow = (cfg.cls == CLS_BOOL) || (cfg.cls == CLS_BYTE);
  end

  assign a_masked  = in_value & vm;
  assign b_masked  = acc_value & vm;
  assign ai_masked = in_index & im;
  assign bi_masked = acc_index & im;

  // compares at element and index width, values signed by flipping the top bit when sgn is set, indexes always signed
  assign a_lt_b   = (a_masked ^ vflip) < (b_masked ^ vflip);
  assign b_lt_a   = (b_masked ^ vflip) < (a_masked ^ vflip);
  assign ai_lt_bi = (ai_masked ^ iflip) < (bi_masked ^ iflip);

  // operation select, products finish one stage later
  always_comb begin
    ta       = (a_masked != 64'h0);
    tb       = (b_masked != 64'h0);
    a        = a_masked;
    b        = b_masked;
    take_in  = 1'b0;
    err      = 1'b0;
    use_prod = 1'b0;
    if (cfg.cls == CLS_BOOL &&
        (cfg.op == OP_BAND || cfg.op == OP_BOR || cfg.op == OP_BXOR)) begin
      a = {63'h0, ta};
      b = {63'h0, tb};
    end
    rv = b;
    ri = pair ? bi_masked : acc_index;
    case (cfg.op)
      OP_MAX, OP_MIN: begin
        if (cfg.cls != CLS_INT) begin
          err = 1'b1;
        end else if (cfg.op == OP_MAX) begin
          rv = a_lt_b ? b : a;
        end else begin
          rv = a_lt_b ? a : b;
        end
      end
      OP_SUM: begin
        if (narrow) begin
          err = 1'b1;
        end else begin
          rv = (a + b) & vm;
          if (pair) begin
            ri = (ai_masked + bi_masked) & im;
          end
        end
      end
      OP_PROD: begin
        if (narrow) begin
          err = 1'b1;
        end else begin
          use_prod = 1'b1;
        end
      end
      OP_LAND, OP_LOR, OP_LXOR: begin
        if (narrow && cfg.cls != CLS_BOOL || pair) begin
          err = 1'b1;
        end else if (cfg.op == OP_LAND) begin
          rv = {63'h0, ta & tb};
        end else if (cfg.op == OP_LOR) begin
          rv = {63'h0, ta | tb};
        end else begin
          rv = {63'h0, ta ^ tb};
        end
      end
      OP_BAND, OP_BOR, OP_BXOR: begin
        if (pair) begin
          err = 1'b1;
        end else if (cfg.op == OP_BAND) begin
          rv = a & b;
        end else if (cfg.op == OP_BOR) begin
          rv = a | b;
        end else begin
          rv = a ^ b;
        end
      end
      OP_MAXLOC, OP_MINLOC: begin
        if (!pair) begin
          err = 1'b1;
        end else begin
          if (a_masked == b_masked) begin
            take_in = ai_lt_bi;
          end else if (cfg.op == OP_MAXLOC) begin
            take_in = b_lt_a;
          end else begin
            take_in = a_lt_b;
          end
          if (take_in) begin
            rv = a;
            ri = ai_masked;
          end
        end
      end
      OP_REPLACE: begin
        rv = a;
        if (pair) begin
          ri = ai_masked;
        end
      end
      OP_NOOP: begin
        rv = b;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    value = rv & vm;
    index = ri;
  end

endmodule

`default_nettype wire
